@@ design/mgr_pkg.sv @@
package mgr_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SELECT,
      ST_SCROLL,
      ST_SQUARE,
      ST_PINCH,
      ST_SWSUM,
      ST_SWDIV,
      ST_SWIPE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic select;
      logic scroll;
      logic square;
      logic pinch;
      logic swsum;
      logic swdiv;
      logic swipe;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_move;
      logic is_bad;
      logic cnt_two;
      logic cnt_three;
      logic emit_last;
   } sts_type;

   localparam logic [1:0] OP_DOWN = 2'd0;
   localparam logic [1:0] OP_MOVE = 2'd1;
   localparam logic [1:0] OP_UP   = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [1:0] KIND_GESTURE = 2'd3;

   localparam logic [7:0] G_SCROLL_UP   = 8'd0;
   localparam logic [7:0] G_SCROLL_DOWN = 8'd1;
   localparam logic [7:0] G_PINCH_IN    = 8'd2;
   localparam logic [7:0] G_PINCH_OUT   = 8'd3;
   localparam logic [7:0] G_SWIPE_LEFT  = 8'd4;
   localparam logic [7:0] G_SWIPE_RIGHT = 8'd5;
   localparam logic [7:0] G_SWIPE_UP    = 8'd6;
   localparam logic [7:0] G_SWIPE_DOWN  = 8'd7;

   localparam logic [1:0] CSR_SCROLL = 2'd0;
   localparam logic [1:0] CSR_PINCH  = 2'd1;
   localparam logic [1:0] CSR_SWIPE  = 2'd2;

   localparam logic [15:0] SCROLL_THR_RST = 16'd20;
   localparam logic [31:0] PINCH_THR_RST  = 32'd2000;
   localparam logic [15:0] SWIPE_THR_RST  = 16'd50;

   // ceil(2^20 / 3), exact for magnitudes below 2^19
   localparam logic [18:0] RECIP3 = 19'd349526;

endpackage

@@ design/mgr_ctrl.sv @@
module mgr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mgr_pkg::sts_type sts,
   output mgr_pkg::cmd_type cmd,
   output logic             busy,
   output logic             rsp_valid
);
   import mgr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (sts.is_bad)       state_in = ST_IDLE;
            else if (sts.is_move) state_in = ST_SELECT;
            else                  state_in = ST_EMIT;
         end
         ST_SELECT: begin
            if (sts.cnt_two)        state_in = ST_SCROLL;
            else if (sts.cnt_three) state_in = ST_SWSUM;
            else                    state_in = ST_EMIT;
         end
         ST_SCROLL: state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_PINCH;
         ST_PINCH:  state_in = ST_EMIT;
         ST_SWSUM:  state_in = ST_SWDIV;
         ST_SWDIV:  state_in = ST_SWIPE;
         ST_SWIPE:  state_in = ST_EMIT;
         ST_EMIT:   if (sts.emit_last) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && start;
      cmd.update = (state_ff == ST_UPDATE);
      cmd.select = (state_ff == ST_SELECT);
      cmd.scroll = (state_ff == ST_SCROLL);
      cmd.square = (state_ff == ST_SQUARE);
      cmd.pinch  = (state_ff == ST_PINCH);
      cmd.swsum  = (state_ff == ST_SWSUM);
      cmd.swdiv  = (state_ff == ST_SWDIV);
      cmd.swipe  = (state_ff == ST_SWIPE);
      cmd.emit   = (state_ff == ST_EMIT);
      busy       = (state_ff != ST_IDLE);
      rsp_valid  = (state_ff == ST_EMIT);
   end

endmodule

@@ design/mgr_dp.sv @@
module mgr_dp #(
   parameter int MAX_CONTACTS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  mgr_pkg::cmd_type    cmd,
   output mgr_pkg::sts_type    sts,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic [1:0]          req_op,
   input  logic [7:0]          req_contact_id,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic [31:0]         req_tick_now,
   output logic [1:0]          rsp_event_kind,
   output logic [7:0]          rsp_event_code,
   output logic signed [31:0]  rsp_event_value,
   output logic [31:0]         rsp_event_time,
   output logic                rsp_last_of_run
);
   import mgr_pkg::*;

   localparam int IW = $clog2(MAX_CONTACTS);
   localparam int CW = $clog2(MAX_CONTACTS + 1);

   // latched report
   logic [1:0]         op_ff;
   logic [7:0]         id_ff;
   logic signed [15:0] x_ff, y_ff;
   logic [31:0]        tick_ff;

   // thresholds
   logic [15:0] scroll_thr_ff, swipe_thr_ff;
   logic [31:0] pinch_thr_ff;

   // slot table
   logic               act_ff [MAX_CONTACTS];
   logic [7:0]         cid_ff [MAX_CONTACTS];
   logic signed [15:0] cx_ff  [MAX_CONTACTS];
   logic signed [15:0] cy_ff  [MAX_CONTACTS];
   logic signed [15:0] sx_ff  [MAX_CONTACTS];
   logic signed [15:0] sy_ff  [MAX_CONTACTS];
   logic [CW-1:0]      cnt_ff;

   // gathered copies of the lowest active slots
   logic signed [15:0] g_cx_ff [3], g_cx_in [3];
   logic signed [15:0] g_cy_ff [3], g_cy_in [3];
   logic signed [15:0] g_sx_ff [3], g_sx_in [3];
   logic signed [15:0] g_sy_ff [3], g_sy_in [3];
   logic [IW-1:0]      g_idx_ff [3], g_idx_in [3];

   logic [31:0]        sq_ff [4];
   logic               negx_ff, negy_ff;
   logic [17:0]        magx_ff, magy_ff;
   logic signed [17:0] ax_ff, ay_ff;

   // event buffer
   logic [1:0]  ek_ff [3];
   logic [7:0]  ec_ff [3];
   logic [31:0] ev_ff [3];
   logic [1:0]  ecnt_ff, eidx_ff;

   // slot searches
   logic          free_found, hit_found;
   logic [IW-1:0] free_idx, hit_idx;
   logic [1:0]    rank;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      hit_found  = 1'b0;
      hit_idx    = '0;
      for (int i = 0; i < MAX_CONTACTS; i++) begin
         if (!free_found && !act_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
         if (!hit_found && act_ff[i] && cid_ff[i] == id_ff) begin
            hit_found = 1'b1;
            hit_idx   = IW'(i);
         end
      end
   end

   always_comb begin
      rank = '0;
      for (int k = 0; k < 3; k++) begin
         g_cx_in[k]  = g_cx_ff[k];
         g_cy_in[k]  = g_cy_ff[k];
         g_sx_in[k]  = g_sx_ff[k];
         g_sy_in[k]  = g_sy_ff[k];
         g_idx_in[k] = g_idx_ff[k];
      end
      for (int i = 0; i < MAX_CONTACTS; i++) begin
         if (act_ff[i] && rank != 2'd3) begin
            g_cx_in[rank]  = cx_ff[i];
            g_cy_in[rank]  = cy_ff[i];
            g_sx_in[rank]  = sx_ff[i];
            g_sy_in[rank]  = sy_ff[i];
            g_idx_in[rank] = IW'(i);
            rank           = rank + 2'd1;
         end
      end
   end

   // scroll
   logic signed [16:0] dy0, dy1, thr17;
   logic signed [17:0] ysum, yrnd, yhalf;
   logic               scr_up, scr_down;

   always_comb begin
      dy0   = 17'(g_cy_ff[0]) - 17'(g_sy_ff[0]);
      dy1   = 17'(g_cy_ff[1]) - 17'(g_sy_ff[1]);
      thr17 = $signed({1'b0, scroll_thr_ff});
      scr_down = (dy0 > thr17) && (dy1 > thr17);
      scr_up   = (dy0 < -thr17) && (dy1 < -thr17);
      ysum  = 18'(dy0) + 18'(dy1);
      yrnd  = ysum + $signed({17'd0, ysum[17]});
      yhalf = yrnd >>> 1;
   end

   // squared distances
   logic signed [16:0] dd [4];
   logic signed [33:0] pp [4];

   always_comb begin
      dd[0] = 17'(g_cx_ff[1]) - 17'(g_cx_ff[0]);
      dd[1] = 17'(g_cy_ff[1]) - 17'(g_cy_ff[0]);
      dd[2] = 17'(g_sx_ff[1]) - 17'(g_sx_ff[0]);
      dd[3] = 17'(g_sy_ff[1]) - 17'(g_sy_ff[0]);
      for (int k = 0; k < 4; k++) begin
         pp[k] = dd[k] * dd[k];
      end
   end

   // pinch
   logic [32:0] dc, ds;
   logic        pin_out, pin_in;
   logic [32:0] pdiff;

   always_comb begin
      dc      = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      ds      = {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};
      pin_out = {1'b0, dc} > ({1'b0, ds} + {2'b0, pinch_thr_ff});
      pin_in  = ({1'b0, dc} + {2'b0, pinch_thr_ff}) < {1'b0, ds};
      pdiff   = pin_out ? (dc - ds) : (ds - dc);
   end

   // swipe
   logic signed [18:0] tsx, tsy;
   logic [36:0]        qx_full, qy_full;
   logic [16:0]        qx, qy;
   logic signed [17:0] ax_in, ay_in, t18, swv;
   logic               sw_hit;
   logic [7:0]         sw_code;

   always_comb begin
      tsx = 19'(17'(g_cx_ff[0]) - 17'(g_sx_ff[0]))
          + 19'(17'(g_cx_ff[1]) - 17'(g_sx_ff[1]))
          + 19'(17'(g_cx_ff[2]) - 17'(g_sx_ff[2]));
      tsy = 19'(17'(g_cy_ff[0]) - 17'(g_sy_ff[0]))
          + 19'(17'(g_cy_ff[1]) - 17'(g_sy_ff[1]))
          + 19'(17'(g_cy_ff[2]) - 17'(g_sy_ff[2]));
      qx_full = 37'(magx_ff) * 37'(RECIP3);
      qy_full = 37'(magy_ff) * 37'(RECIP3);
      qx      = qx_full[36:20];
      qy      = qy_full[36:20];
      ax_in   = negx_ff ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      ay_in   = negy_ff ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      t18     = $signed({2'b0, swipe_thr_ff});
      sw_hit  = 1'b1;
      sw_code = G_SWIPE_RIGHT;
      if (ax_ff > t18)       sw_code = G_SWIPE_RIGHT;
      else if (ax_ff < -t18) sw_code = G_SWIPE_LEFT;
      else if (ay_ff > t18)  sw_code = G_SWIPE_DOWN;
      else if (ay_ff < -t18) sw_code = G_SWIPE_UP;
      else                   sw_hit  = 1'b0;
      swv = (ax_ff != 18'sd0) ? ax_ff : ay_ff;
   end

   // thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_thr_ff <= SCROLL_THR_RST;
         pinch_thr_ff  <= PINCH_THR_RST;
         swipe_thr_ff  <= SWIPE_THR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCROLL: scroll_thr_ff <= csr_wdata[15:0];
            CSR_PINCH:  pinch_thr_ff  <= csr_wdata;
            CSR_SWIPE:  swipe_thr_ff  <= csr_wdata[15:0];
            default:    ;
         endcase
      end
   end

   // slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CONTACTS; i++) act_ff[i] <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (cmd.update) begin
            if (op_ff == OP_DOWN && free_found) begin
               act_ff[free_idx] <= 1'b1;
               cid_ff[free_idx] <= id_ff;
               cx_ff[free_idx]  <= x_ff;
               cy_ff[free_idx]  <= y_ff;
               sx_ff[free_idx]  <= x_ff;
               sy_ff[free_idx]  <= y_ff;
               cnt_ff           <= cnt_ff + CW'(1);
            end else if (op_ff == OP_MOVE && hit_found) begin
               cx_ff[hit_idx] <= x_ff;
               cy_ff[hit_idx] <= y_ff;
            end else if (op_ff == OP_UP && hit_found) begin
               act_ff[hit_idx] <= 1'b0;
               cnt_ff          <= cnt_ff - CW'(1);
            end
         end
         if (cmd.scroll && (scr_up || scr_down)) begin
            sy_ff[g_idx_ff[0]] <= g_cy_ff[0];
            sy_ff[g_idx_ff[1]] <= g_cy_ff[1];
         end
         if (cmd.swipe && sw_hit) begin
            for (int i = 0; i < MAX_CONTACTS; i++) begin
               if (act_ff[i]) begin
                  sx_ff[i] <= cx_ff[i];
                  sy_ff[i] <= cy_ff[i];
               end
            end
         end
      end
   end

   // report latch and gesture pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         id_ff   <= req_contact_id;
         x_ff    <= req_pos_x;
         y_ff    <= req_pos_y;
         tick_ff <= req_tick_now;
      end
      if (cmd.select) begin
         for (int k = 0; k < 3; k++) begin
            g_cx_ff[k]  <= g_cx_in[k];
            g_cy_ff[k]  <= g_cy_in[k];
            g_sx_ff[k]  <= g_sx_in[k];
            g_sy_ff[k]  <= g_sy_in[k];
            g_idx_ff[k] <= g_idx_in[k];
         end
      end
      if (cmd.scroll && (scr_up || scr_down)) begin
         g_sy_ff[0] <= g_cy_ff[0];
         g_sy_ff[1] <= g_cy_ff[1];
      end
      if (cmd.square) begin
         for (int k = 0; k < 4; k++) sq_ff[k] <= pp[k][31:0];
      end
      if (cmd.swsum) begin
         negx_ff <= tsx[18];
         negy_ff <= tsy[18];
         magx_ff <= tsx[18] ? 18'(-tsx) : tsx[17:0];
         magy_ff <= tsy[18] ? 18'(-tsy) : tsy[17:0];
      end
      if (cmd.swdiv) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
   end

   // event buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         ecnt_ff <= '0;
         eidx_ff <= '0;
      end else begin
         if (cmd.load) begin
            ecnt_ff <= '0;
            eidx_ff <= '0;
         end
         if (cmd.update && op_ff != OP_NONE) begin
            ek_ff[0] <= op_ff;
            ec_ff[0] <= id_ff;
            ev_ff[0] <= {y_ff, x_ff};
            ecnt_ff  <= 2'd1;
         end
         if (cmd.scroll && (scr_up || scr_down)) begin
            ek_ff[ecnt_ff] <= KIND_GESTURE;
            ec_ff[ecnt_ff] <= scr_down ? G_SCROLL_DOWN : G_SCROLL_UP;
            ev_ff[ecnt_ff] <= {{14{yhalf[17]}}, yhalf};
            ecnt_ff        <= ecnt_ff + 2'd1;
         end
         if (cmd.pinch && (pin_out || pin_in)) begin
            ek_ff[ecnt_ff] <= KIND_GESTURE;
            ec_ff[ecnt_ff] <= pin_out ? G_PINCH_OUT : G_PINCH_IN;
            ev_ff[ecnt_ff] <= pdiff[31:0];
            ecnt_ff        <= ecnt_ff + 2'd1;
         end
         if (cmd.swipe && sw_hit) begin
            ek_ff[ecnt_ff] <= KIND_GESTURE;
            ec_ff[ecnt_ff] <= sw_code;
            ev_ff[ecnt_ff] <= {{14{swv[17]}}, swv};
            ecnt_ff        <= ecnt_ff + 2'd1;
         end
         if (cmd.emit) eidx_ff <= eidx_ff + 2'd1;
      end
   end

   always_comb begin
      sts.is_move   = (op_ff == OP_MOVE);
      sts.is_bad    = (op_ff == OP_NONE);
      sts.cnt_two   = (cnt_ff == CW'(2));
      sts.cnt_three = (cnt_ff == CW'(3));
      sts.emit_last = (eidx_ff == ecnt_ff - 2'd1);
   end

   assign rsp_event_kind  = ek_ff[eidx_ff];
   assign rsp_event_code  = ec_ff[eidx_ff];
   assign rsp_event_value = ev_ff[eidx_ff];
   assign rsp_event_time  = tick_ff;
   assign rsp_last_of_run = sts.emit_last;

endmodule

@@ design/multitouch_gesture_recognizer.sv @@
// channel   | handshake         | words
// request   | start / busy      | op, contact id, x, y, tick
// response  | rsp_valid strobe  | kind, code, value, time, last flag
// csr       | csr_we            | index 0..2, 32-bit data
//
// one report at a time: the unused op goes back to idle, down or up emits its one event
// word, a move without two or three contacts emits its one word, a two-finger move runs
// the scroll, square and pinch stages and a three-finger move runs the swipe sum, divide
// and swipe stages (squaring, divide by three via reciprocal) before the event words
// synchronous reset clears the slot valid bits and count and restores the default thresholds
// response words stream one per cycle; the receiver has no stall
module multitouch_gesture_recognizer #(
   parameter int MAX_CONTACTS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [7:0]         req_contact_id,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [31:0]        req_tick_now,
   output logic               rsp_valid,
   output logic [1:0]         rsp_event_kind,
   output logic [7:0]         rsp_event_code,
   output logic signed [31:0] rsp_event_value,
   output logic [31:0]        rsp_event_time,
   output logic               rsp_last_of_run,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import mgr_pkg::*;

   cmd_type cmd;   // sequencer strobes into the datapath
   sts_type sts;   // op decode, contact count and buffer status back

   // sequencer: idle, table update, gesture stages, event drain
   mgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // slot table, gesture math, thresholds and event buffer
   mgr_dp #(
      .MAX_CONTACTS (MAX_CONTACTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_op          (req_op),
      .req_contact_id  (req_contact_id),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_tick_now    (req_tick_now),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_code  (rsp_event_code),
      .rsp_event_value (rsp_event_value),
      .rsp_event_time  (rsp_event_time),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef NO_ASSERTIONS
   // response words only come out during a report
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response word while idle");

   // an accepted report makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted report not taken up");

   // a report's words are contiguous and end at the last flag
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |=> rsp_valid) else $error("gap in burst");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |=> !busy) else $error("busy after last word");
`endif

endmodule

@@ tb/multitouch_gesture_recognizer_tb.sv @@
`timescale 1ns / 100ps

module multitouch_gesture_recognizer_tb;
   import mgr_pkg::*;

   localparam int SLOTS = 10;
   localparam int CYCLE_LIMIT = 200000;
   // index past the last register, the block must drop it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         op;
      logic [7:0]         id;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [31:0]        tick;
   } report_type;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  code;
      logic [31:0] value;
      logic [31:0] stamp;
      logic        last;
   } touch_event_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_op = OP_DOWN;
   logic [7:0]         req_contact_id = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [31:0]        req_tick_now = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_event_kind;
   logic [7:0]         rsp_event_code;
   logic signed [31:0] rsp_event_value;
   logic [31:0]        rsp_event_time;
   logic               rsp_last_of_run;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = CSR_SCROLL;
   logic [31:0]        csr_wdata = '0;

   multitouch_gesture_recognizer #(.MAX_CONTACTS(SLOTS)) dut (.*);

   always #6 clock = ~clock;

   // shadow of the block: thresholds and slot table
   logic [15:0] scroll_thr;
   logic [31:0] pinch_thr;
   logic [15:0] swipe_thr;
   logic        act [SLOTS];
   logic [7:0]  owner [SLOTS];
   longint      cur_x [SLOTS], cur_y [SLOTS], org_x [SLOTS], org_y [SLOTS];
   int          live;

   report_type      pending_reports [$];
   touch_event_type expected_events [$];
   int  errors = 0;
   int  reports_taken = 0;
   int  gestures_seen = 0;
   int  cycles = 0;
   int  gap = 0;
   bit  quiet = 0;

   function automatic touch_event_type mk(logic [1:0] k, logic [7:0] c, logic [31:0] v,
                                          logic [31:0] t);
      touch_event_type e;
      e.kind = k; e.code = c; e.value = v; e.stamp = t; e.last = 1'b0;
      return e;
   endfunction

   // gesture search after a move, appends to the local list
   task automatic find_gestures(logic [31:0] t, inout touch_event_type evs [$]);
      int a, b, cnt;
      longint dy0, dy1, dc, ds, sx, sy, ax, ay, thr;
      logic [7:0] code;
      bit hit;
      a = -1; b = -1;
      if (live == 2) begin
         for (int i = 0; i < SLOTS; i++)
            if (act[i]) begin
               if (a < 0) a = i;
               else if (b < 0) b = i;
            end
         if (a >= 0 && b >= 0) begin
            thr = scroll_thr;
            dy0 = cur_y[a] - org_y[a];
            dy1 = cur_y[b] - org_y[b];
            hit = 1;
            if (dy0 > thr && dy1 > thr) code = G_SCROLL_DOWN;
            else if (dy0 < -thr && dy1 < -thr) code = G_SCROLL_UP;
            else hit = 0;
            if (hit) begin
               evs.push_back(mk(KIND_GESTURE, code, 32'((dy0 + dy1) / 2), t));
               org_y[a] = cur_y[a];
               org_y[b] = cur_y[b];
            end
            // pinch sees the start y that scroll may just have moved
            dc = (cur_x[b] - cur_x[a]) ** 2 + (cur_y[b] - cur_y[a]) ** 2;
            ds = (org_x[b] - org_x[a]) ** 2 + (org_y[b] - org_y[a]) ** 2;
            thr = longint'(pinch_thr);
            if (dc > ds + thr) evs.push_back(mk(KIND_GESTURE, G_PINCH_OUT, 32'(dc - ds), t));
            else if (dc < ds - thr)
               evs.push_back(mk(KIND_GESTURE, G_PINCH_IN, 32'(ds - dc), t));
         end
      end
      if (live == 3) begin
         sx = 0; sy = 0; cnt = 0;
         for (int i = 0; i < SLOTS; i++)
            if (act[i] && cnt < 3) begin
               sx += cur_x[i] - org_x[i];
               sy += cur_y[i] - org_y[i];
               cnt++;
            end
         ax = sx / 3;   // truncates toward zero
         ay = sy / 3;
         thr = swipe_thr;
         hit = 1;
         if (ax > thr) code = G_SWIPE_RIGHT;
         else if (ax < -thr) code = G_SWIPE_LEFT;
         else if (ay > thr) code = G_SWIPE_DOWN;
         else if (ay < -thr) code = G_SWIPE_UP;
         else hit = 0;
         if (hit) begin
            evs.push_back(mk(KIND_GESTURE, code, 32'((ax != 0) ? ax : ay), t));
            for (int i = 0; i < SLOTS; i++)
               if (act[i]) begin
                  org_x[i] = cur_x[i];
                  org_y[i] = cur_y[i];
               end
         end
      end
   endtask

   // events caused by one accepted report, in order
   task automatic predict_events(report_type r);
      touch_event_type evs [$];
      int f;
      if (r.op == OP_NONE) return;
      evs.push_back(mk(r.op, r.id, {r.y, r.x}, r.tick));
      if (r.op == OP_DOWN) begin
         for (int i = 0; i < SLOTS; i++)
            if (!act[i]) begin
               act[i] = 1; owner[i] = r.id;
               cur_x[i] = r.x; org_x[i] = r.x;
               cur_y[i] = r.y; org_y[i] = r.y;
               live++;
               break;
            end
      end else begin
         f = -1;
         for (int i = 0; i < SLOTS; i++)
            if (act[i] && owner[i] == r.id) begin
               f = i;
               break;
            end
         if (r.op == OP_MOVE) begin
            if (f >= 0) begin
               cur_x[f] = r.x;
               cur_y[f] = r.y;
            end
            find_gestures(r.tick, evs);
         end else if (f >= 0) begin
            act[f] = 0;
            live--;
         end
      end
      evs[evs.size() - 1].last = 1'b1;
      foreach (evs[i]) expected_events.push_back(evs[i]);
   endtask

   // driver: holds a word until start meets a low busy
   always @(posedge clock) begin
      report_type r;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            r.op = req_op; r.id = req_contact_id; r.x = req_pos_x;
            r.y = req_pos_y; r.tick = req_tick_now;
            predict_events(r);
            reports_taken++;
            if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
         end
         if (!start || !busy) begin
            if (gap > 0) begin
               gap--;
               start <= 1'b0;
            end else if (pending_reports.size() != 0) begin
               r = pending_reports.pop_front();
               req_op <= r.op;
               req_contact_id <= r.id;
               req_pos_x <= r.x;
               req_pos_y <= r.y;
               req_tick_now <= r.tick;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed word is checked against the oldest prediction
   always @(posedge clock) begin
      touch_event_type e;
      if (!reset && rsp_valid) begin
         if (expected_events.size() == 0) begin
            $error("unexpected event kind=%0d code=%0d", rsp_event_kind, rsp_event_code);
            errors++;
         end else begin
            e = expected_events.pop_front();
            if (rsp_event_kind == KIND_GESTURE) gestures_seen++;
            if (rsp_event_kind !== e.kind) begin
               $error("event_kind exp %0d got %0d", e.kind, rsp_event_kind); errors++;
            end
            if (rsp_event_code !== e.code) begin
               $error("event_code exp %0d got %0d", e.code, rsp_event_code); errors++;
            end
            if (rsp_event_value !== e.value) begin
               $error("event_value exp %h got %h", e.value, rsp_event_value); errors++;
            end
            if (rsp_event_time !== e.stamp) begin
               $error("event_time exp %h got %h", e.stamp, rsp_event_time); errors++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run exp %0d got %0d", e.last, rsp_last_of_run); errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic add(logic [1:0] op, logic [7:0] id, int x, int y);
      report_type r;
      r.op = op; r.id = id; r.x = 16'(x); r.y = 16'(y);
      r.tick = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
      pending_reports.push_back(r);
   endtask

   function automatic int clamp16(int v);
      return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
   endfunction

   // wait until the block has drained, including silent op 3 work
   task automatic settle();
      while (pending_reports.size() != 0 || start || expected_events.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // all writes while idle; an out-of-range index rides along
   task automatic program_thresholds(logic [31:0] s, logic [31:0] p, logic [31:0] w);
      logic [1:0]  idx [4];
      logic [31:0] val [4];
      idx = '{CSR_SCROLL, CSR_PINCH, CSR_SWIPE, CSR_UNUSED};
      val = '{s, p, w, $urandom};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      scroll_thr = s[15:0];
      pinch_thr = p;
      swipe_thr = w[15:0];
   endtask

   // release whatever contacts the table still holds
   task automatic clear_table();
      for (int i = 0; i < SLOTS; i++)
         if (act[i]) add(OP_UP, owner[i], 0, 0);
      settle();
   endtask

   // one well-formed gesture run: downs, moves around a center, ups
   task automatic gesture_run();
      int n, moves, span, cx, cy;
      int px [3], py [3];
      logic [7:0] ids [3];
      n = $urandom_range(2, 3);
      ids[0] = 8'($urandom);
      for (int i = 1; i < 3; i++) ids[i] = ids[0] + 8'(i);
      span = ($urandom_range(0, 3) == 0) ? 3 * int'(swipe_thr) + 30 : 200;
      if (span > 8000) span = 8000;
      cx = $urandom_range(0, 40000) - 20000;
      cy = $urandom_range(0, 40000) - 20000;
      for (int i = 0; i < n; i++) begin
         px[i] = cx + $urandom_range(0, 200) - 100;
         py[i] = cy + $urandom_range(0, 200) - 100;
         add(OP_DOWN, ids[i], px[i], py[i]);
      end
      moves = $urandom_range(3, 10);
      for (int m = 0; m < moves; m++) begin
         int k;
         k = $urandom_range(0, n - 1);
         px[k] = clamp16(px[k] + $urandom_range(0, 2 * span) - span);
         py[k] = clamp16(py[k] + $urandom_range(0, 2 * span) - span);
         add(OP_MOVE, ids[k], px[k], py[k]);
      end
      for (int i = 0; i < n; i++) add(OP_UP, ids[i], px[i], py[i]);
   endtask

   // unordered reports, unused op, full-range fields, table overflow
   task automatic noise_burst();
      for (int i = 0; i < 12; i++)
         add(2'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 65535) - 32768,
             $urandom_range(0, 65535) - 32768);
      for (int i = 0; i < SLOTS + 1; i++) add(OP_DOWN, 8'(i), i * 3000 - 32768, 32767 - i);
      add(OP_MOVE, 8'd3, 32767, -32768);
   endtask

   task automatic random_phase(int runs);
      for (int r = 0; r < runs; r++) gesture_run();
      noise_burst();
      settle();
      clear_table();
   endtask

   initial begin
      scroll_thr = SCROLL_THR_RST;
      pinch_thr = PINCH_THR_RST;
      swipe_thr = SWIPE_THR_RST;
      live = 0;
      for (int i = 0; i < SLOTS; i++) begin
         act[i] = 0; owner[i] = '0;
         cur_x[i] = 0; cur_y[i] = 0; org_x[i] = 0; org_y[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: scroll both ways, pinch both ways, all four swipes
      add(OP_DOWN, 8'd0, 0, 0);
      add(OP_DOWN, 8'd255, 100, 0);
      add(OP_MOVE, 8'd0, 0, 30);         // one finger only, no scroll
      add(OP_MOVE, 8'd255, 100, 30);     // scroll down
      add(OP_MOVE, 8'd255, 300, 30);     // pinch out
      add(OP_MOVE, 8'd255, 100, 30);     // back to the start distance, no pinch
      add(OP_MOVE, 8'd0, 0, -10);
      add(OP_MOVE, 8'd255, 100, -11);    // scroll up, odd sum
      add(OP_MOVE, 8'd77, 5, 5);         // unknown id still checks
      add(OP_UP, 8'd77, 0, 0);           // unknown id up
      add(OP_NONE, 8'd1, -1, -1);        // unused op
      add(OP_DOWN, 8'd9, 0, 0);
      add(OP_MOVE, 8'd9, 300, 0);        // swipe right
      add(OP_MOVE, 8'd9, -200, 0);       // swipe left
      add(OP_MOVE, 8'd9, -200, 300);     // swipe down
      add(OP_MOVE, 8'd9, -200, -200);    // swipe up
      add(OP_MOVE, 8'd9, -32768, 32767);
      add(OP_UP, 8'd9, 0, 0);
      add(OP_UP, 8'd0, 0, 0);
      add(OP_UP, 8'd255, 0, 0);
      add(OP_DOWN, 8'd170, -32768, 32767);
      add(OP_DOWN, 8'd85, 32767, -32768);
      add(OP_MOVE, 8'd170, 32767, -32768); // biggest pinch, value wraps
      settle();
      clear_table();

      program_thresholds(32'd0, 32'd0, 32'd0);
      random_phase(3);
      program_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_phase(3);
      program_thresholds($urandom_range(5, 80), $urandom_range(500, 40000),
                         $urandom_range(10, 120));
      random_phase(4);
      program_thresholds(SCROLL_THR_RST, PINCH_THR_RST, SWIPE_THR_RST);
      quiet = 1;                         // back-to-back to the end
      random_phase(4);

      $display("%0d reports taken, %0d gesture events, thresholds at both extremes",
               reports_taken, gestures_seen);
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
